// ===== hdl/pdm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared types, constants and helpers of the PID (derivative on measurement)
// core: register map, configuration struct and bit-serial unit widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pdm_pkg;

  // bit-serial arithmetic unit widths
  localparam int MUL_AW = 64;   // multiplicand / product
  localparam int MUL_BW = 24;   // multiplier, one bit per cycle
  localparam int DIV_NW = 64;   // dividend, left aligned
  localparam int DIV_DW = 48;   // divisor
  localparam int DIV_CW = 7;    // quotient bit count

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_KP     = 3'd0;
  localparam reg_idx_t REG_KI     = 3'd1;
  localparam reg_idx_t REG_KD     = 3'd2;
  localparam reg_idx_t REG_ILIM   = 3'd3;
  localparam reg_idx_t REG_OLIM   = 3'd4;
  localparam reg_idx_t REG_CUTOFF = 3'd5;

  localparam logic [14:0] OLIM_RESET   = 15'd32767;
  localparam logic [9:0]  CUTOFF_RESET = 10'd20;

  // arithmetic constants
  localparam logic [15:0] DT_MIN_US    = 16'd1000;
  localparam logic [15:0] DT_MAX_US    = 16'd50000;
  localparam logic [19:0] US_PER_S     = 20'd1000000;
  localparam logic [18:0] HALF_US      = 19'd500000;
  localparam logic [18:0] TWO_PI_Q16   = 19'd411775;
  localparam logic [23:0] DERIV_SCALE  = 24'd16000000;
  localparam logic [47:0] ALPHA_DEN_K  = 48'd65536000000;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic [14:0]        ilim;
    logic [14:0]        olim;
    logic [9:0]         cutoff;
  } cfg_t;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

  function automatic logic [16:0] abs17(input logic [16:0] v);
    return v[16] ? 17'(-v) : v;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [32:0] abs33(input logic [32:0] v);
    return v[32] ? 33'(-v) : v;
  endfunction

  function automatic logic [51:0] abs52(input logic [51:0] v);
    return v[51] ? 52'(-v) : v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pid_derivative_on_measurement_core.sv =====
// ----------------------------------------------------------------------------
// pid_derivative_on_measurement_core
// PID controller with derivative on measurement and a first-order low-pass
// on the derivative, built around a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
//  channel  dir  fields (lsb first)                          handshake
//  in_      in   tdata: error_in, measured_value, step_us;   tvalid/tready
//                tuser: integ_hold
//  out_     out  tdata: drive_out                            tvalid/tready
//  cfg_     in   six registers at byte address 4*index       APB, pready = 1
//
//  One item at a time; between accepted transactions run divisions of 31, 39,
//  40 and 61 quotient bits (first two only for an active unheld integrator,
//  third only after the first item) and up to eight products.
//  Reset clears the integrator, derivative filter and previous measurement.
//  A finished result waits in the output register; the next item is taken
//  meanwhile and only the final load stalls on a full output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_derivative_on_measurement_core
  import pdm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [47:0]       in_tdata,   // error_in, measured_value, step_us
  input  wire logic              in_tuser,   // integ_hold
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,  // drive_out
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_CAP   = 20'h00002,
    S_INCM  = 20'h00004,
    S_INCD  = 20'h00008,
    S_IACC  = 20'h00010,
    S_DERM  = 20'h00020,
    S_DERD  = 20'h00040,
    S_RAW   = 20'h00080,
    S_XM1   = 20'h00100,
    S_XM2   = 20'h00200,
    S_ALPHA = 20'h00400,
    S_ALPHD = 20'h00800,
    S_FILTM = 20'h01000,
    S_FILT  = 20'h02000,
    S_KPM   = 20'h04000,
    S_KIM   = 20'h08000,
    S_KDM   = 20'h10000,
    S_OUT   = 20'h20000,
    S_SAT   = 20'h40000,
    S_WAIT  = 20'h80000
  } state_t;

  cfg_t cfg;

  // arithmetic unit connections
  logic              mul_start, mul_busy, mul_done;
  logic [MUL_AW-1:0] mul_a, mul_p;
  logic [MUL_BW-1:0] mul_b;
  logic              div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_num, div_q;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_CW-1:0] div_cnt;

  // control and state registers
  state_t             state_r, state_nxt, ret_r, ret_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [15:0]        prev_r, prev_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] filt_r, filt_nxt;
  logic               out_valid_r, out_valid_nxt;
  // working registers
  logic [15:0]        e_r, m_r, dt_r;
  logic               hold_r;
  logic signed [31:0] raw_r, raw_nxt;
  logic [31:0]        cap_r, cap_nxt;
  logic [DIV_DW-1:0]  den_r, den_nxt;
  logic               dmneg_r, dmneg_nxt;
  logic               diffneg_r, diffneg_nxt;
  logic               psign_r, psign_nxt;
  logic signed [51:0] sum_r, sum_nxt;
  logic [15:0]        out_data_r, out_data_nxt;

  // combinational helpers
  logic        in_fire;
  logic [15:0] dt_in;
  logic        iact;
  logic [38:0] inc_num;
  logic signed [33:0] acc_sum, cap_s;
  logic signed [16:0] dm;
  logic [39:0] raw_num;
  logic [60:0] alpha_num;
  logic signed [32:0] diff;
  logic [33:0] filt_rnd;
  logic signed [34:0] filt_sum;
  logic [51:0] term;
  logic [35:0] y_mag;
  logic [15:0] y_lim;

  pdm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pdm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  pdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .cnt   (div_cnt),
    .busy  (div_busy),
    .done  (div_done),
    .q     (div_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign iact       = (cfg.ki != '0) && (cfg.ilim != '0);

  // clamp the time step
  always_comb begin
    if (in_tdata[47:32] < DT_MIN_US) begin
      dt_in = DT_MIN_US;
    end else if (in_tdata[47:32] > DT_MAX_US) begin
      dt_in = DT_MAX_US;
    end else begin
      dt_in = in_tdata[47:32];
    end
  end

  // datapath helpers
  assign inc_num   = {mul_p[30:0], 8'b0} + 39'(HALF_US);
  assign cap_s     = $signed({2'b00, cap_r});
  assign acc_sum   = 34'(acc_r) + (e_r[15] ? -$signed(34'(div_q[19:0]))
                                            : $signed(34'(div_q[19:0])));
  assign dm        = $signed(17'($signed(m_r))) - $signed(17'($signed(prev_r)));
  assign raw_num   = mul_p[39:0] + 40'(dt_r[15:1]);
  assign alpha_num = {mul_p[44:0], 16'b0} + 61'(den_r[DIV_DW-1:1]);
  assign diff      = $signed(33'(raw_r)) - $signed(33'(filt_r));
  assign filt_rnd  = 34'((mul_p[49:0] + 50'd32768) >> 16);
  assign filt_sum  = 35'(filt_r) + (diffneg_r ? -$signed(35'(filt_rnd))
                                              : $signed(35'(filt_rnd)));
  assign y_mag     = 36'((abs52(sum_r) + 52'd32768) >> 16);
  assign y_lim     = (y_mag > 36'(cfg.olim)) ? 16'(cfg.olim) : y_mag[15:0];

  // term added to the output sum, taken from the last product
  always_comb begin
    case (state_r)
      S_KIM:   term = 52'({mul_p[31:0], 8'b0});
      S_KDM:   term = 52'(mul_p[46:0]);
      S_OUT:   term = 52'({mul_p[46:0], 4'b0});
      default: term = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    have_prev_nxt = have_prev_r;
    prev_nxt      = prev_r;
    acc_nxt       = acc_r;
    filt_nxt      = filt_r;
    raw_nxt       = raw_r;
    cap_nxt       = cap_r;
    den_nxt       = den_r;
    dmneg_nxt     = dmneg_r;
    diffneg_nxt   = diffneg_r;
    psign_nxt     = psign_r;
    sum_nxt       = sum_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    div_cnt       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CAP;
        end
      end
      // integrator cap = ilim * 65536 / |ki|
      S_CAP: begin
        if (iact && !hold_r) begin
          div_start = 1'b1;
          div_num   = {cfg.ilim, 16'b0, 33'b0};
          div_den   = DIV_DW'(abs16(cfg.ki));
          div_cnt   = DIV_CW'(31);
          ret_nxt   = S_INCM;
          state_nxt = S_WAIT;
        end else begin
          if (!iact) begin
            acc_nxt = '0;
          end
          state_nxt = S_DERM;
        end
      end
      S_INCM: begin
        cap_nxt   = div_q[31:0];
        mul_start = 1'b1;
        mul_a     = MUL_AW'(abs16(e_r));
        mul_b     = MUL_BW'(dt_r);
        ret_nxt   = S_INCD;
        state_nxt = S_WAIT;
      end
      S_INCD: begin
        div_start = 1'b1;
        div_num   = {inc_num, 25'b0};
        div_den   = DIV_DW'(US_PER_S);
        div_cnt   = DIV_CW'(39);
        ret_nxt   = S_IACC;
        state_nxt = S_WAIT;
      end
      // accumulate and clamp to +/- cap
      S_IACC: begin
        if (acc_sum > cap_s) begin
          acc_nxt = $signed(cap_r);
        end else if (acc_sum < -cap_s) begin
          acc_nxt = -$signed(cap_r);
        end else begin
          acc_nxt = acc_sum[31:0];
        end
        state_nxt = S_DERM;
      end
      S_DERM: begin
        prev_nxt      = m_r;
        have_prev_nxt = 1'b1;
        if (have_prev_r) begin
          dmneg_nxt = dm[16];
          mul_start = 1'b1;
          mul_a     = MUL_AW'(abs17(dm));
          mul_b     = DERIV_SCALE;
          ret_nxt   = S_DERD;
          state_nxt = S_WAIT;
        end else begin
          raw_nxt   = '0;
          filt_nxt  = '0;
          state_nxt = S_XM1;
        end
      end
      S_DERD: begin
        div_start = 1'b1;
        div_num   = {raw_num, 24'b0};
        div_den   = DIV_DW'(dt_r);
        div_cnt   = DIV_CW'(40);
        ret_nxt   = S_RAW;
        state_nxt = S_WAIT;
      end
      // derivative opposes the change in measurement
      S_RAW: begin
        raw_nxt   = dmneg_r ? $signed(div_q[31:0]) : -$signed(div_q[31:0]);
        state_nxt = S_XM1;
      end
      S_XM1: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(TWO_PI_Q16);
        mul_b     = MUL_BW'(cfg.cutoff);
        ret_nxt   = S_XM2;
        state_nxt = S_WAIT;
      end
      S_XM2: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(mul_p[28:0]);
        mul_b     = MUL_BW'(dt_r);
        ret_nxt   = S_ALPHA;
        state_nxt = S_WAIT;
      end
      S_ALPHA: begin
        den_nxt   = DIV_DW'(mul_p[44:0]) + ALPHA_DEN_K;
        state_nxt = S_ALPHD;
      end
      S_ALPHD: begin
        div_start = 1'b1;
        div_num   = {alpha_num, 3'b0};
        div_den   = den_r;
        div_cnt   = DIV_CW'(61);
        ret_nxt   = S_FILTM;
        state_nxt = S_WAIT;
      end
      S_FILTM: begin
        diffneg_nxt = diff[32];
        mul_start   = 1'b1;
        mul_a       = MUL_AW'(abs33(diff));
        mul_b       = MUL_BW'(div_q[16:0]);
        ret_nxt     = S_FILT;
        state_nxt   = S_WAIT;
      end
      S_FILT: begin
        filt_nxt  = filt_sum[31:0];
        state_nxt = S_KPM;
      end
      // output sum kp*e*256 + ki*acc + kd*filt*16
      S_KPM: begin
        sum_nxt   = '0;
        psign_nxt = cfg.kp[15] ^ e_r[15];
        mul_start = 1'b1;
        mul_a     = MUL_AW'(abs16(e_r));
        mul_b     = MUL_BW'(abs16(cfg.kp));
        ret_nxt   = S_KIM;
        state_nxt = S_WAIT;
      end
      S_KIM: begin
        sum_nxt   = sum_r + (psign_r ? -$signed(term) : $signed(term));
        psign_nxt = cfg.ki[15] ^ acc_r[31];
        mul_start = 1'b1;
        mul_a     = MUL_AW'(abs32(acc_r));
        mul_b     = MUL_BW'(abs16(cfg.ki));
        ret_nxt   = S_KDM;
        state_nxt = S_WAIT;
      end
      S_KDM: begin
        sum_nxt   = sum_r + (psign_r ? -$signed(term) : $signed(term));
        psign_nxt = cfg.kd[15] ^ filt_r[31];
        mul_start = 1'b1;
        mul_a     = MUL_AW'(abs32(filt_r));
        mul_b     = MUL_BW'(abs16(cfg.kd));
        ret_nxt   = S_OUT;
        state_nxt = S_WAIT;
      end
      S_OUT: begin
        sum_nxt   = sum_r + (psign_r ? -$signed(term) : $signed(term));
        state_nxt = S_SAT;
      end
      // round, saturate, load the output register once it is free
      S_SAT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = sum_r[51] ? 16'(-y_lim) : y_lim;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WAIT: begin
        if (mul_done || div_done) begin
          state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      acc_r       <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      have_prev_r <= have_prev_nxt;
      prev_r      <= prev_nxt;
      acc_r       <= acc_nxt;
      filt_r      <= filt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_r    <= in_tdata[15:0];
      m_r    <= in_tdata[31:16];
      dt_r   <= dt_in;
      hold_r <= in_tuser;
    end
    raw_r      <= raw_nxt;
    cap_r      <= cap_nxt;
    den_r      <= den_nxt;
    dmneg_r    <= dmneg_nxt;
    diffneg_r  <= diffneg_nxt;
    psign_r    <= psign_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  // one item in flight
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("item accepted while another is in flight");

  // shared units are never restarted mid operation
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // integrator lands inside the cap after an update
  a_acc_capped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IACC |=>
      ($signed(acc_r) <= $signed({1'b0, cap_r})) &&
      ($signed(acc_r) >= -$signed({1'b0, cap_r})))
    else $error("integrator outside its cap");

endmodule

`default_nettype wire

// ===== hdl/pdm_mul.sv =====
// ----------------------------------------------------------------------------
// pdm_mul
// Unsigned shift-and-add multiplier: one multiplier bit per cycle, stops as
// soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_mul
  import pdm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [MUL_AW-1:0] a,
  input  wire logic [MUL_BW-1:0] b,
  output logic                   busy,
  output logic                   done,
  output logic [MUL_AW-1:0]      p
);

  logic [MUL_AW-1:0] a_r;
  logic [MUL_BW-1:0] b_r;
  logic [MUL_AW-1:0] p_r;
  logic              busy_r;
  logic              done_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r[MUL_BW-1:1] == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // shift multiplier right, multiplicand left, add on a set bit
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_r <= p_r + a_r;
      end
      a_r <= {a_r[MUL_AW-2:0], 1'b0};
      b_r <= {1'b0, b_r[MUL_BW-1:1]};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = p_r;

endmodule

`default_nettype wire

// ===== hdl/pdm_div.sv =====
// ----------------------------------------------------------------------------
// pdm_div
// Restoring divider: one quotient bit per cycle. The dividend arrives left
// aligned and the caller gives the number of quotient bits to produce.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_div
  import pdm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  input  wire logic [DIV_CW-1:0] cnt,
  output logic                   busy,
  output logic                   done,
  output logic [DIV_NW-1:0]      q
);

  logic [DIV_DW:0]   rem_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r[DIV_DW-1:0], num_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= cnt;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // bring down one dividend bit, subtract where the divisor fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
      num_r <= {num_r[DIV_NW-2:0], 1'b0};
      q_r   <= {q_r[DIV_NW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign q    = q_r;

endmodule

`default_nettype wire

// ===== hdl/pdm_regs.sv =====
// ----------------------------------------------------------------------------
// pdm_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_regs
  import pdm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[CFG_AW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp     <= '0;
      cfg_r.ki     <= '0;
      cfg_r.kd     <= '0;
      cfg_r.ilim   <= '0;
      cfg_r.olim   <= OLIM_RESET;
      cfg_r.cutoff <= CUTOFF_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_KP:     cfg_r.kp     <= pwdata[15:0];
        REG_KI:     cfg_r.ki     <= pwdata[15:0];
        REG_KD:     cfg_r.kd     <= pwdata[15:0];
        REG_ILIM:   cfg_r.ilim   <= pwdata[14:0];
        REG_OLIM:   cfg_r.olim   <= pwdata[14:0];
        REG_CUTOFF: cfg_r.cutoff <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_KP:     prdata = CFG_DW'(cfg_r.kp);
      REG_KI:     prdata = CFG_DW'(cfg_r.ki);
      REG_KD:     prdata = CFG_DW'(cfg_r.kd);
      REG_ILIM:   prdata = CFG_DW'(cfg_r.ilim);
      REG_OLIM:   prdata = CFG_DW'(cfg_r.olim);
      REG_CUTOFF: prdata = CFG_DW'(cfg_r.cutoff);
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== dv/pid_derivative_on_measurement_core_test.sv =====
// ----------------------------------------------------------------------------
// pid_derivative_on_measurement_core_test
// Self-checking bench for the PID core: drives measurement transactions and
// APB register writes, predicts each drive value in fixed point and compares
// it with the result stream under random back-pressure and input gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import pdm_pkg::*;

// Predicts drive values and holds the ones not yet returned
class drive_scoreboard;

  logic signed [15:0] kp, ki, kd;
  logic [14:0]        ilim, olim;
  logic [9:0]         cutoff;
  longint             integ_acc, last_m, filt_deriv;
  bit                 have_prev;
  logic [15:0]        drive_q[$];
  int                 errors;

  function new();
    kp = 0; ki = 0; kd = 0; ilim = 0;
    olim = OLIM_RESET; cutoff = CUTOFF_RESET;
    integ_acc = 0; last_m = 0; filt_deriv = 0; have_prev = 0;
    errors = 0;
  endfunction

  function void write_reg(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_KP:     kp = v[15:0];
      REG_KI:     ki = v[15:0];
      REG_KD:     kd = v[15:0];
      REG_ILIM:   ilim = v[14:0];
      REG_OLIM:   olim = v[14:0];
      REG_CUTOFF: cutoff = v[9:0];
      default: ;
    endcase
  endfunction

  // round to nearest, ties away from zero; d > 0
  function longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function void note_input(logic signed [15:0] e_in, logic signed [15:0] m_in,
                           logic [15:0] step, bit hold);
    longint e, m, dt, aki, cap, raw, x, alpha, sum, y, lim;
    e = e_in;
    m = m_in;
    dt = step;
    if (dt < 1000) dt = 1000;
    if (dt > 50000) dt = 50000;

    // integrator, cleared while disabled
    if (ki != 0 && ilim != 0) begin
      if (!hold) begin
        aki = ki;
        if (aki < 0) aki = -aki;
        cap = (longint'(ilim) * 65536) / aki;
        integ_acc += round_div(e * dt * 256, 1000000);
        if (integ_acc > cap) integ_acc = cap;
        if (integ_acc < -cap) integ_acc = -cap;
      end
    end else begin
      integ_acc = 0;
    end

    // derivative on measurement, restart filter on first transaction
    raw = 0;
    if (have_prev) begin
      raw = round_div(-(m - last_m) * 16000000, dt);
    end else begin
      have_prev = 1;
      filt_deriv = 0;
    end
    last_m = m;

    x = longint'(cutoff) * dt * 411775;
    alpha = round_div(x * 65536, x + 64'd65536000000);
    filt_deriv += round_div(alpha * (raw - filt_deriv), 65536);

    sum = longint'(kp) * e * 256 + longint'(ki) * integ_acc
        + longint'(kd) * filt_deriv * 16;
    y = round_div(sum, 65536);
    lim = olim;
    if (y > lim) y = lim;
    if (y < -lim) y = -lim;
    drive_q.push_back(y[15:0]);
  endfunction

  function void check_result(logic [15:0] got);
    logic [15:0] want;
    if (drive_q.size() == 0) begin
      $error("drive_out: no transaction expected, actual %0d", $signed(got));
      errors++;
      return;
    end
    want = drive_q.pop_front();
    if (got !== want) begin
      $error("drive_out: expected %0d, actual %0d", $signed(want), $signed(got));
      errors++;
    end
  endfunction
endclass

module pid_derivative_on_measurement_core_test;
  import pdm_pkg::*;

  localparam reg_idx_t REG_UNUSED = 3'd6;
  localparam int       STALL_LIMIT = 20000;
  localparam int       HOLD_OFF_CYCLES = 3000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [47:0]       in_tdata = '0;   // error_in, measured_value, step_us
  logic              in_tuser = 1'b0; // integ_hold
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;       // drive_out
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  drive_scoreboard   sb = new();
  int                tx_idle = 0;
  int                rx_idle = 0;
  logic              rx_hold_off = 1'b0;
  int                quiet_cycles = 0;
  logic signed [15:0] last_meas = 0;

  pid_derivative_on_measurement_core u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= !rx_hold_off && ($urandom_range(0, 99) >= rx_idle);
  end

  // watch both channels
  always @(posedge clk) begin
    if (in_tvalid && in_tready)
      sb.note_input(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32], in_tuser);
    if (out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_AW'({idx, 2'b00});
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic set_gains(int kp, int ki, int kd, int ilim, int olim, int cutoff);
    write_reg(REG_KP, 32'(kp));
    write_reg(REG_KI, 32'(ki));
    write_reg(REG_KD, 32'(kd));
    write_reg(REG_ILIM, 32'(ilim));
    write_reg(REG_OLIM, 32'(olim));
    write_reg(REG_CUTOFF, 32'(cutoff));
  endtask

  // offer one transaction, with an optional gap before it
  task automatic send_item(logic [15:0] e, logic [15:0] m, logic [15:0] dt, bit hold);
    logic ready;
    if ($urandom_range(0, 99) < tx_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {dt, m, e};
    in_tuser <= hold;
    do begin
      @(negedge clk);
      ready = in_tready;
      @(posedge clk);
    end while (!ready);
    last_meas = m;
  endtask

  // wait until every drive value is back
  task automatic drain();
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (sb.drive_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_item();
    logic [15:0] e, m, dt;
    e = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
    m = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                    : 16'(last_meas + $urandom_range(0, 511) - 256);
    case ($urandom_range(0, 9))
      0:       dt = 16'($urandom_range(0, 999));
      1:       dt = 16'($urandom_range(50001, 65535));
      default: dt = 16'($urandom_range(1000, 50000));
    endcase
    send_item(e, m, dt, $urandom_range(0, 4) == 0);
  endtask

  task automatic random_config();
    int kp, ki, kd, ilim, olim, cutoff;
    kp = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 1023) - 512;
    ki = ($urandom_range(0, 5) == 0) ? 0 :
         ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 1023) - 512;
    kd = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 63) - 32;
    ilim = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 32767);
    olim = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 32767);
    cutoff = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1023);
    set_gains(kp, ki, kd, ilim, olim, cutoff);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first transaction, step clamping and field extremes
    set_gains(256, 256, 256, 4096, 32767, 20);
    send_item(16'd1000, 16'd500, 16'd0, 1'b0);
    send_item(16'h7fff, 16'h7fff, 16'd999, 1'b0);
    send_item(16'h8000, 16'h8000, 16'd1000, 1'b0);
    send_item(16'h7fff, 16'h7fff, 16'd50000, 1'b0);
    send_item(16'h8000, 16'h0000, 16'd50001, 1'b0);
    send_item(16'hffff, 16'hffff, 16'd65535, 1'b1);
    drain();

    // extreme gains, zero output bound, unknown register
    set_gains(-32768, 32767, -32768, 32767, 0, 1023);
    write_reg(REG_UNUSED, 32'hffff_ffff);
    send_item(16'h7fff, 16'h8000, 16'd1000, 1'b0);
    send_item(16'h8000, 16'h7fff, 16'd1000, 1'b0);
    drain();
    set_gains(32767, -32768, 32767, 32767, 32767, 0);
    send_item(16'h7fff, 16'h0000, 16'd50000, 1'b0);
    send_item(16'h7fff, 16'h1000, 16'd50000, 1'b0);
    send_item(16'h8000, 16'h8000, 16'd1000, 1'b0);
    drain();

    // held integrator across a tighter cap, then integrator disabled
    set_gains(100, 20, 50, 8000, 32767, 1000);
    send_item(16'h7fff, 16'h0100, 16'd50000, 1'b0);
    send_item(16'h7fff, 16'h0200, 16'd50000, 1'b0);
    drain();
    write_reg(REG_KI, 32'(-30000));
    send_item(16'h7fff, 16'h0300, 16'd50000, 1'b1);
    send_item(16'h1234, 16'h0300, 16'd20000, 1'b1);
    send_item(16'h1234, 16'h0300, 16'd20000, 1'b0);
    drain();
    write_reg(REG_ILIM, 32'd0);
    send_item(16'h4000, 16'h0400, 16'd3000, 1'b0);
    drain();
    write_reg(REG_KI, 32'd0);
    write_reg(REG_ILIM, 32'd500);
    send_item(16'h4000, 16'h0500, 16'd3000, 1'b0);
    drain();

    // random segments: receiver-heavy idling, sender-heavy, then none
    for (int seg = 0; seg < 12; seg++) begin
      tx_idle = (seg < 4) ? 27 : (seg < 8) ? 51 : 0;
      rx_idle = (seg < 4) ? 51 : (seg < 8) ? 27 : 0;
      random_config();
      if (seg == 8) begin
        fork
          begin
            rx_hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            rx_hold_off <= 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 130; n++) random_item();
      drain();
    end

    if (sb.errors == 0 && sb.drive_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/pdm_pkg.sv
hdl/pdm_mul.sv
hdl/pdm_div.sv
hdl/pdm_regs.sv
hdl/pid_derivative_on_measurement_core.sv
dv/pid_derivative_on_measurement_core_test.sv
